[hdl/ttpbc_pkg.sv]
// ttpbc_pkg: shared constants, codes, state type and controller interface structs
// for the periodic bandwidth check block; no dependencies
package ttpbc_pkg;

    // table geometry
    localparam int TABLE_SLOTS    = 16;
    localparam int INTERVAL_LIMIT = 16;
    localparam int MIN_EXPONENT   = 3;
    localparam int LOW_SPEED_SHIFT = 3;   // low speed size times 8

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    // field and register widths
    localparam int KIND_W     = 2;
    localparam int EXPO_W     = 5;
    localparam int BYTES_W    = 10;
    localparam int LIMIT_W    = 15;
    localparam int OVH_W      = 8;
    localparam int BPB_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int FREE_W     = 16;

    // internal widths
    localparam int SCALED_W   = BYTES_W + LOW_SPEED_SHIFT;
    localparam int NUM_W      = SCALED_W + 1;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int SIZE_W     = 16;
    localparam int CNT_W      = 16;
    localparam int USED_W     = 16;
    localparam int CHARGE_W   = SIZE_W + 1;
    localparam int NPK_W      = USED_W + 1;
    localparam int PROD_W     = NPK_W + CHARGE_W;
    localparam int REM_W      = ((TABLE_SLOTS > CNT_W) ? TABLE_SLOTS : CNT_W) + 1;

    // item kinds (any other code is a query)
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_OVH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_OVH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPB      = 2'd3;

    // configuration reset values
    localparam logic [LIMIT_W-1:0] RST_LIMIT    = 15'd1285;
    localparam logic [OVH_W-1:0]   RST_FULL_OVH = 8'd20;
    localparam logic [OVH_W-1:0]   RST_LOW_OVH  = 8'd128;
    localparam logic [BPB_W-1:0]   RST_BPB      = 7'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIVIDE,
        ST_UPDATE,
        ST_WALK_START,
        ST_WALK,
        ST_FLUSH,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear_table;
        logic div_start;
        logic table_write;
        logic walk_init;
        logic walk_step;
        logic walk_tail;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_clear;
        logic add_go;
        logic div_last;
        logic walk_last;
        logic pipe_busy;
    } t_status;

endpackage

[hdl/ttpbc_div.sv]
// ttpbc_div: restoring divider, one quotient bit per cycle
// depends on ttpbc_pkg
module ttpbc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ttpbc_pkg::NUM_W-1:0]   i_numer,
    input  logic [ttpbc_pkg::BPB_W-1:0]   i_divisor,
    output logic                          o_last,
    output logic [ttpbc_pkg::NUM_W-1:0]   o_quot
);

    logic                              r_busy;
    logic [ttpbc_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ttpbc_pkg::BPB_W-1:0]       r_rem;
    logic [ttpbc_pkg::NUM_W-1:0]       r_quot;
    logic [ttpbc_pkg::BPB_W-1:0]       r_div;

    logic [ttpbc_pkg::BPB_W:0]         trial;
    logic                              fits;
    logic [ttpbc_pkg::BPB_W:0]         diff;

    // one trial subtraction per cycle
    always_comb begin
        trial = {r_rem, r_quot[ttpbc_pkg::NUM_W-1]};
        fits  = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= ttpbc_pkg::DIV_CNT_W'(ttpbc_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != ttpbc_pkg::DIV_CNT_W'(1));
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_numer;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[ttpbc_pkg::BPB_W-1:0] : trial[ttpbc_pkg::BPB_W-1:0];
            r_quot <= {r_quot[ttpbc_pkg::NUM_W-2:0], fits};
        end
    end

    assign o_last = r_busy && (r_cnt == ttpbc_pkg::DIV_CNT_W'(1));
    assign o_quot = r_quot;

endmodule

[hdl/ttpbc_datapath.sv]
// ttpbc_datapath: configuration registers, interval slot table, divider,
// slot walk pipeline and result registers; depends on ttpbc_pkg, ttpbc_div
module ttpbc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ttpbc_pkg::t_cmd                      i_cmd,
    output ttpbc_pkg::t_status                   o_status,
    input  logic                                 i_cfg_we,
    input  logic [ttpbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttpbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [ttpbc_pkg::KIND_W-1:0]         i_kind,
    input  logic                                 i_is_low_speed,
    input  logic [ttpbc_pkg::EXPO_W-1:0]         i_poll_exponent,
    input  logic [ttpbc_pkg::BYTES_W-1:0]        i_packet_bytes,
    output logic signed [ttpbc_pkg::FREE_W-1:0]  o_blocks_free,
    output logic                                 o_oversubscribed,
    output logic                                 o_rejected
);

    // configuration
    logic [ttpbc_pkg::LIMIT_W-1:0] r_limit;
    logic [ttpbc_pkg::OVH_W-1:0]   r_full_ovh;
    logic [ttpbc_pkg::OVH_W-1:0]   r_low_ovh;
    logic [ttpbc_pkg::BPB_W-1:0]   r_bpb;

    // captured item
    logic [ttpbc_pkg::KIND_W-1:0]   r_kind;
    logic                           r_low;
    logic [ttpbc_pkg::SLOT_W-1:0]   r_slot;
    logic [ttpbc_pkg::BYTES_W-1:0]  r_bytes;
    logic                           r_rejected;

    // slot table, entries without a valid bit read as zero
    logic [ttpbc_pkg::TABLE_SLOTS-1:0] r_valid;
    logic [ttpbc_pkg::SIZE_W-1:0]      r_size_tab [ttpbc_pkg::TABLE_SLOTS];
    logic [ttpbc_pkg::CNT_W-1:0]       r_cnt_tab  [ttpbc_pkg::TABLE_SLOTS];
    logic [ttpbc_pkg::OVH_W-1:0]       r_ovh_tab  [ttpbc_pkg::TABLE_SLOTS];

    // walk state
    logic [ttpbc_pkg::SLOT_W-1:0]   r_idx;
    logic [ttpbc_pkg::REM_W-1:0]    r_rem;
    logic [ttpbc_pkg::SIZE_W-1:0]   r_size;
    logic [ttpbc_pkg::OVH_W-1:0]    r_ovh;
    logic                           r_a_valid;
    logic [ttpbc_pkg::NPK_W-1:0]    r_npk;
    logic [ttpbc_pkg::CHARGE_W-1:0] r_charge;
    logic                           r_b_valid;
    logic [ttpbc_pkg::PROD_W-1:0]   r_prod;
    logic [ttpbc_pkg::USED_W-1:0]   r_used;

    // result
    logic [ttpbc_pkg::FREE_W-1:0]   r_blocks_free;
    logic                           r_oversubscribed;
    logic                           r_out_rejected;

    logic                           expo_ok;
    logic [ttpbc_pkg::BPB_W-1:0]    divisor;
    logic [ttpbc_pkg::SCALED_W-1:0] scaled;
    logic [ttpbc_pkg::NUM_W-1:0]    numer;
    logic [ttpbc_pkg::NUM_W-1:0]    quot;
    logic                           div_last;

    logic [ttpbc_pkg::SLOT_W-1:0]   rd_addr;
    logic                           e_valid;
    logic [ttpbc_pkg::SIZE_W-1:0]   e_size;
    logic [ttpbc_pkg::CNT_W-1:0]    e_cnt;
    logic [ttpbc_pkg::OVH_W-1:0]    e_ovh;

    logic [ttpbc_pkg::OVH_W-1:0]    ovh_sel;
    logic [ttpbc_pkg::SIZE_W:0]     s0_sum;
    logic [ttpbc_pkg::SIZE_W-1:0]   w_size;
    logic [ttpbc_pkg::CNT_W-1:0]    w_cnt;
    logic [ttpbc_pkg::OVH_W-1:0]    w_ovh;

    logic [ttpbc_pkg::REM_W-1:0]    rem_sum;
    logic [ttpbc_pkg::REM_W-1:0]    rem_mask;
    logic [ttpbc_pkg::REM_W-1:0]    rem_m;
    logic [ttpbc_pkg::REM_W-1:0]    npk_full;
    logic [ttpbc_pkg::NPK_W-1:0]    npk_c;
    logic [ttpbc_pkg::SIZE_W-1:0]   size_m;
    logic [ttpbc_pkg::OVH_W-1:0]    ovh_m;
    logic [ttpbc_pkg::SIZE_W-1:0]   size_next;
    logic [ttpbc_pkg::OVH_W-1:0]    ovh_next;
    logic [ttpbc_pkg::PROD_W-1:0]   prod;
    logic [ttpbc_pkg::PROD_W-1:0]   used_sum;
    logic [ttpbc_pkg::USED_W-1:0]   used_next;
    logic [ttpbc_pkg::FREE_W:0]     free_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= ttpbc_pkg::RST_LIMIT;
            r_full_ovh <= ttpbc_pkg::RST_FULL_OVH;
            r_low_ovh  <= ttpbc_pkg::RST_LOW_OVH;
            r_bpb      <= ttpbc_pkg::RST_BPB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttpbc_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data[ttpbc_pkg::LIMIT_W-1:0];
                ttpbc_pkg::CFG_FULL_OVH: r_full_ovh <= i_cfg_data[ttpbc_pkg::OVH_W-1:0];
                ttpbc_pkg::CFG_LOW_OVH:  r_low_ovh  <= i_cfg_data[ttpbc_pkg::OVH_W-1:0];
                ttpbc_pkg::CFG_BPB:      r_bpb      <= i_cfg_data[ttpbc_pkg::BPB_W-1:0];
                default: ;
            endcase
        end
    end

    // interval check on the incoming exponent
    always_comb begin
        expo_ok = (int'(i_poll_exponent) >= ttpbc_pkg::MIN_EXPONENT)
               && (int'(i_poll_exponent) < ttpbc_pkg::INTERVAL_LIMIT)
               && (int'(i_poll_exponent) - ttpbc_pkg::MIN_EXPONENT < ttpbc_pkg::TABLE_SLOTS);
    end

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_low      <= i_is_low_speed;
            r_slot     <= ttpbc_pkg::SLOT_W'(i_poll_exponent
                                              - ttpbc_pkg::EXPO_W'(ttpbc_pkg::MIN_EXPONENT));
            r_bytes    <= i_packet_bytes;
            r_rejected <= (i_kind == ttpbc_pkg::KIND_ADD) && !expo_ok;
        end
    end

    // block rounding: ceil(size / bytes_per_block) through the serial divider
    always_comb begin
        divisor = (r_bpb == '0) ? ttpbc_pkg::BPB_W'(1) : r_bpb;
        scaled  = r_low ? {r_bytes, ttpbc_pkg::LOW_SPEED_SHIFT'(0)}
                        : ttpbc_pkg::SCALED_W'(r_bytes);
        numer   = ttpbc_pkg::NUM_W'(scaled) + ttpbc_pkg::NUM_W'(divisor)
                - ttpbc_pkg::NUM_W'(1);
    end

    ttpbc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_numer   (numer),
        .i_divisor (divisor),
        .o_last    (div_last),
        .o_quot    (quot)
    );

    // single table read port
    always_comb begin
        if (i_cmd.walk_init) begin
            rd_addr = '0;
        end else if (i_cmd.table_write) begin
            rd_addr = r_slot;
        end else begin
            rd_addr = r_idx;
        end
        e_valid = r_valid[rd_addr];
        e_size  = e_valid ? r_size_tab[rd_addr] : '0;
        e_cnt   = e_valid ? r_cnt_tab[rd_addr]  : '0;
        e_ovh   = e_valid ? r_ovh_tab[rd_addr]  : '0;
    end

    // endpoint update of the addressed slot
    always_comb begin
        ovh_sel = r_low ? r_low_ovh : r_full_ovh;
        s0_sum  = (ttpbc_pkg::SIZE_W + 1)'(e_size) + (ttpbc_pkg::SIZE_W + 1)'(quot)
                + (ttpbc_pkg::SIZE_W + 1)'(ovh_sel);
        if (r_slot == '0) begin
            w_size = s0_sum[ttpbc_pkg::SIZE_W] ? '1 : s0_sum[ttpbc_pkg::SIZE_W-1:0];
            w_cnt  = e_cnt;
            w_ovh  = e_ovh;
        end else begin
            w_size = (ttpbc_pkg::SIZE_W'(quot) > e_size) ? ttpbc_pkg::SIZE_W'(quot) : e_size;
            w_cnt  = (e_cnt == '1) ? e_cnt : e_cnt + 1'b1;
            if (r_low) begin
                w_ovh = r_low_ovh;
            end else if (e_ovh == '0) begin
                w_ovh = r_full_ovh;
            end else begin
                w_ovh = e_ovh;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_table) begin
            r_valid <= '0;
        end else if (i_cmd.table_write) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    // table entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.table_write) begin
            r_size_tab[r_slot] <= w_size;
            r_cnt_tab[r_slot]  <= w_cnt;
            r_ovh_tab[r_slot]  <= w_ovh;
        end
    end

    // one slot of the walk: carry remainder, charge whole packets
    always_comb begin
        rem_sum  = (r_rem << 1) + ttpbc_pkg::REM_W'(e_cnt);
        size_m   = (e_size > r_size) ? e_size : r_size;
        ovh_m    = (e_ovh > r_ovh) ? e_ovh : r_ovh;
        npk_full = rem_sum >> r_idx;
        rem_mask = ~({ttpbc_pkg::REM_W{1'b1}} << r_idx);
        rem_m    = rem_sum & rem_mask;
        npk_c    = (|npk_full[ttpbc_pkg::REM_W-1:ttpbc_pkg::USED_W])
                 ? (ttpbc_pkg::NPK_W'(1) << ttpbc_pkg::USED_W)
                 : ttpbc_pkg::NPK_W'(npk_full[ttpbc_pkg::USED_W-1:0]);
        if (rem_m == '0) begin
            size_next = '0;
            ovh_next  = '0;
        end else if (npk_full != '0) begin
            size_next = e_size;
            ovh_next  = ovh_m;
        end else begin
            size_next = size_m;
            ovh_next  = ovh_m;
        end
    end

    // carried walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_idx  <= ttpbc_pkg::SLOT_W'(1);
            r_rem  <= '0;
            r_size <= '0;
            r_ovh  <= '0;
        end else if (i_cmd.walk_step) begin
            r_idx  <= r_idx + 1'b1;
            r_rem  <= rem_m;
            r_size <= size_next;
            r_ovh  <= ovh_next;
        end
    end

    // charge stage: packet count and per-packet cost
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step) begin
            r_npk    <= npk_c;
            r_charge <= ttpbc_pkg::CHARGE_W'(size_m) + ttpbc_pkg::CHARGE_W'(ovh_m);
        end else if (i_cmd.walk_tail) begin
            r_npk    <= ttpbc_pkg::NPK_W'(r_rem != '0);
            r_charge <= ttpbc_pkg::CHARGE_W'(r_size) + ttpbc_pkg::CHARGE_W'(r_ovh);
        end
    end

    // multiply and accumulate stages
    assign prod      = ttpbc_pkg::PROD_W'(r_npk) * ttpbc_pkg::PROD_W'(r_charge);
    assign used_sum  = ttpbc_pkg::PROD_W'(r_used) + r_prod;
    assign used_next = (|used_sum[ttpbc_pkg::PROD_W-1:ttpbc_pkg::USED_W])
                     ? '1 : used_sum[ttpbc_pkg::USED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.walk_step || i_cmd.walk_tail;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_prod <= prod;
        end
        if (i_cmd.walk_init) begin
            r_used <= e_size;
        end else if (r_b_valid) begin
            r_used <= used_next;
        end
    end

    // result registers
    assign free_full = (ttpbc_pkg::FREE_W + 1)'(r_limit) - (ttpbc_pkg::FREE_W + 1)'(r_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_blocks_free    <= free_full[ttpbc_pkg::FREE_W-1:0];
            r_oversubscribed <= free_full[ttpbc_pkg::FREE_W];
            r_out_rejected   <= r_rejected;
        end
    end

    assign o_blocks_free    = r_blocks_free;
    assign o_oversubscribed = r_oversubscribed;
    assign o_rejected       = r_out_rejected;

    // status to the controller
    always_comb begin
        o_status.is_clear  = (r_kind == ttpbc_pkg::KIND_CLEAR);
        o_status.add_go    = (r_kind == ttpbc_pkg::KIND_ADD) && !r_rejected;
        o_status.div_last  = div_last;
        o_status.walk_last = (r_idx == ttpbc_pkg::SLOT_W'(ttpbc_pkg::TABLE_SLOTS - 1));
        o_status.pipe_busy = r_a_valid || r_b_valid;
    end

endmodule

[hdl/ttpbc_ctrl.sv]
// ttpbc_ctrl: sequencing state machine and output handshake
// depends on ttpbc_pkg
module ttpbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ttpbc_pkg::t_cmd     o_cmd,
    input  ttpbc_pkg::t_status  i_status
);

    ttpbc_pkg::t_state r_state;
    ttpbc_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttpbc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ttpbc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ttpbc_pkg::ST_DECODE;
                end
            end
            ttpbc_pkg::ST_DECODE: begin
                if (i_status.is_clear) begin
                    o_cmd.clear_table = 1'b1;
                    n_state           = ttpbc_pkg::ST_WALK_START;
                end else if (i_status.add_go) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ttpbc_pkg::ST_DIVIDE;
                end else begin
                    n_state = ttpbc_pkg::ST_WALK_START;
                end
            end
            ttpbc_pkg::ST_DIVIDE: begin
                if (i_status.div_last) begin
                    n_state = ttpbc_pkg::ST_UPDATE;
                end
            end
            ttpbc_pkg::ST_UPDATE: begin
                o_cmd.table_write = 1'b1;
                n_state           = ttpbc_pkg::ST_WALK_START;
            end
            ttpbc_pkg::ST_WALK_START: begin
                o_cmd.walk_init = 1'b1;
                n_state         = ttpbc_pkg::ST_WALK;
            end
            ttpbc_pkg::ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = ttpbc_pkg::ST_FLUSH;
                end
            end
            ttpbc_pkg::ST_FLUSH: begin
                o_cmd.walk_tail = 1'b1;
                n_state         = ttpbc_pkg::ST_DRAIN;
            end
            ttpbc_pkg::ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ttpbc_pkg::ST_RESULT;
                end
            end
            ttpbc_pkg::ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ttpbc_pkg::ST_IDLE;
                end
            end
            default: n_state = ttpbc_pkg::ST_IDLE;
        endcase
    end

    // output register holds until taken
    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);

    assign o_in_stall  = !i_rst_n || (r_state != ttpbc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/tt_periodic_bandwidth_check.sv]
// tt_periodic_bandwidth_check: top level, joins controller and datapath
// depends on ttpbc_pkg, ttpbc_ctrl, ttpbc_datapath
//
// Periodic bandwidth check for the full and low speed bus behind one
// transaction translator. Each item clears the interval table, adds an
// endpoint or only queries, and gives one result: blocks free, an
// oversubscribed flag and a rejected flag for an add with a bad interval.
// One item is worked at a time. A clear, a query or a rejected add goes
// from decode straight to the slot walk; an add with a valid interval first
// passes the divider that rounds the packet size to blocks one quotient bit
// per cycle and then writes the updated slot. The rest is
// the slot walk, one slot per cycle through a single multiply and
// accumulate. A finished result waits in the output register, so the next
// item is accepted while it is still held.
// Configuration is taken at any time but must only change while idle.
module tt_periodic_bandwidth_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ttpbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ttpbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [ttpbc_pkg::KIND_W-1:0]         i_kind,
    input  logic                                 i_is_low_speed,
    input  logic [ttpbc_pkg::EXPO_W-1:0]         i_poll_exponent,
    input  logic [ttpbc_pkg::BYTES_W-1:0]        i_packet_bytes,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [ttpbc_pkg::FREE_W-1:0]  o_blocks_free,
    output logic                                 o_oversubscribed,
    output logic                                 o_rejected
);

    ttpbc_pkg::t_cmd    cmd;
    ttpbc_pkg::t_status status;

    // sequencing
    ttpbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // table and arithmetic
    ttpbc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_is_low_speed   (i_is_low_speed),
        .i_poll_exponent  (i_poll_exponent),
        .i_packet_bytes   (i_packet_bytes),
        .o_blocks_free    (o_blocks_free),
        .o_oversubscribed (o_oversubscribed),
        .o_rejected       (o_rejected)
    );

endmodule

[hdl/ttpbc_checker.sv]
// ttpbc_checker: port-level assertions for tt_periodic_bandwidth_check
// depends on ttpbc_pkg; bound to the top level at the end of this file
module ttpbc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [ttpbc_pkg::FREE_W-1:0]  o_blocks_free,
    input  logic                                 o_oversubscribed,
    input  logic                                 o_rejected
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blocks_free)
                               && $stable(o_oversubscribed) && $stable(o_rejected))
        else $error("result changed while stalled");

    // an item in work blocks the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an item was taken");

    // a result never appears in the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared too early");

    // a non-negative free count fits in the positive range
    a_free_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_oversubscribed |-> !o_blocks_free[ttpbc_pkg::FREE_W-1])
        else $error("free count negative without oversubscription");

endmodule

bind tt_periodic_bandwidth_check ttpbc_checker u_ttpbc_checker (.*);

[bench/tt_periodic_bandwidth_check_tb.sv]
// tt_periodic_bandwidth_check_tb: self-checking bench for the periodic bandwidth check
// depends on ttpbc_pkg and tt_periodic_bandwidth_check; predicts every result in-bench
// and checks it under bursty input, patterned output stalls and several register settings
module tt_periodic_bandwidth_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // kinds the package leaves unnamed; both read as a query
    localparam logic [ttpbc_pkg::KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [ttpbc_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int TAIL_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 60;
    localparam int PHASES         = 8;

    typedef struct {
        logic [ttpbc_pkg::KIND_W-1:0]  kind;
        logic                          is_low_speed;
        logic [ttpbc_pkg::EXPO_W-1:0]  poll_exponent;
        logic [ttpbc_pkg::BYTES_W-1:0] packet_bytes;
    } t_endpoint_req;

    typedef struct {
        logic signed [ttpbc_pkg::FREE_W-1:0] blocks_free;
        logic                                oversubscribed;
        logic                                rejected;
    } t_budget_report;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_LONG,
        RX_PERIODIC
    } t_rx_mode;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [ttpbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [ttpbc_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [ttpbc_pkg::KIND_W-1:0]        i_kind = '0;
    logic                                i_is_low_speed = 1'b0;
    logic [ttpbc_pkg::EXPO_W-1:0]        i_poll_exponent = '0;
    logic [ttpbc_pkg::BYTES_W-1:0]       i_packet_bytes = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [ttpbc_pkg::FREE_W-1:0] o_blocks_free;
    logic                                o_oversubscribed;
    logic                                o_rejected;

    tt_periodic_bandwidth_check uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_is_low_speed   (i_is_low_speed),
        .i_poll_exponent  (i_poll_exponent),
        .i_packet_bytes   (i_packet_bytes),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_blocks_free    (o_blocks_free),
        .o_oversubscribed (o_oversubscribed),
        .o_rejected       (o_rejected)
    );

    always #5 i_clk = ~i_clk;

    // register copies as last written
    logic [ttpbc_pkg::LIMIT_W-1:0] cfg_limit    = ttpbc_pkg::RST_LIMIT;
    logic [ttpbc_pkg::OVH_W-1:0]   cfg_full_ovh = ttpbc_pkg::RST_FULL_OVH;
    logic [ttpbc_pkg::OVH_W-1:0]   cfg_low_ovh  = ttpbc_pkg::RST_LOW_OVH;
    logic [ttpbc_pkg::BPB_W-1:0]   cfg_bpb      = ttpbc_pkg::RST_BPB;

    // interval table copy
    logic [ttpbc_pkg::SIZE_W-1:0] slot_size  [ttpbc_pkg::TABLE_SLOTS] = '{default: '0};
    logic [ttpbc_pkg::CNT_W-1:0]  slot_count [ttpbc_pkg::TABLE_SLOTS] = '{default: '0};
    logic [ttpbc_pkg::OVH_W-1:0]  slot_ovh   [ttpbc_pkg::TABLE_SLOTS] = '{default: '0};

    t_endpoint_req  pending_reqs[$];
    t_budget_report expected_reports[$];
    t_endpoint_req  drv_item;
    int             burst_left = 0;
    int             gap_left = 0;
    int             mismatch_count = 0;
    int             report_idx = 0;
    int             idle_cycles = 0;
    t_rx_mode       stall_mode = RX_STREAM;
    int             stall_phase_left = 0;
    logic [7:0]     stall_tick = '0;

    // slot update for one add; returns 1 when the interval is out of range
    function automatic logic add_endpoint(t_endpoint_req req);
        int unsigned slot, nbytes, per_block, nblk, ovh, sum;
        if (req.poll_exponent < ttpbc_pkg::MIN_EXPONENT
            || req.poll_exponent >= ttpbc_pkg::INTERVAL_LIMIT)
            return 1'b1;
        slot = req.poll_exponent - ttpbc_pkg::MIN_EXPONENT;
        if (slot >= ttpbc_pkg::TABLE_SLOTS)
            return 1'b1;
        nbytes = 32'(req.packet_bytes);
        if (req.is_low_speed)
            nbytes = nbytes << ttpbc_pkg::LOW_SPEED_SHIFT;
        per_block = (cfg_bpb == '0) ? 32'd1 : 32'(cfg_bpb);
        nblk = (nbytes + per_block - 1) / per_block;
        ovh = req.is_low_speed ? 32'(cfg_low_ovh) : 32'(cfg_full_ovh);
        if (slot == 0) begin
            // slot zero sums size plus overhead, saturating
            sum = 32'(slot_size[0]) + nblk + ovh;
            slot_size[0] = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
        end else begin
            if (slot_count[slot] != 16'hFFFF)
                slot_count[slot] = slot_count[slot] + ttpbc_pkg::CNT_W'(1);
            if (nblk > 32'(slot_size[slot]))
                slot_size[slot] = nblk[15:0];
            if (req.is_low_speed)
                slot_ovh[slot] = cfg_low_ovh;
            else if (slot_ovh[slot] == '0)
                slot_ovh[slot] = cfg_full_ovh;
        end
        return 1'b0;
    endfunction

    // walk the slots carrying doubled remainders, used count saturates at 16 bits
    function automatic logic [ttpbc_pkg::USED_W-1:0] blocks_used();
        longint unsigned used, carry, size, ovh, npk;
        int i;
        used = 64'(slot_size[0]);
        carry = 0;
        size = 0;
        ovh = 0;
        for (i = 1; i < ttpbc_pkg::TABLE_SLOTS; i++) begin
            carry = 2 * carry + 64'(slot_count[i]);
            if (64'(slot_size[i]) > size)
                size = 64'(slot_size[i]);
            if (64'(slot_ovh[i]) > ovh)
                ovh = 64'(slot_ovh[i]);
            npk = carry >> i;
            used = used + npk * (size + ovh);
            if (used > 64'hFFFF)
                used = 64'hFFFF;
            carry = carry & ((64'd1 << i) - 1);
            if (carry == 0) begin
                size = 0;
                ovh = 0;
            end else if (npk > 0) begin
                size = 64'(slot_size[i]);
            end
        end
        // leftover remainder charges one more packet
        if (carry != 0) begin
            used = used + size + ovh;
            if (used > 64'hFFFF)
                used = 64'hFFFF;
        end
        return used[15:0];
    endfunction

    // expected result for one accepted item, table copy updated on the way
    function automatic t_budget_report predict_report(t_endpoint_req req);
        t_budget_report rpt;
        int free_blocks;
        rpt.rejected = 1'b0;
        if (req.kind == ttpbc_pkg::KIND_CLEAR) begin
            foreach (slot_size[i]) begin
                slot_size[i] = '0;
                slot_count[i] = '0;
                slot_ovh[i] = '0;
            end
        end else if (req.kind == ttpbc_pkg::KIND_ADD) begin
            rpt.rejected = add_endpoint(req);
        end
        free_blocks = int'(cfg_limit) - int'(blocks_used());
        rpt.blocks_free = free_blocks[15:0];
        rpt.oversubscribed = (free_blocks < 0);
        return rpt;
    endfunction

    function automatic t_endpoint_req mk_req(logic [ttpbc_pkg::KIND_W-1:0] kind, logic low,
                                             int expo, int nbytes);
        t_endpoint_req req;
        req.kind = kind;
        req.is_low_speed = low;
        req.poll_exponent = expo[ttpbc_pkg::EXPO_W-1:0];
        req.packet_bytes = nbytes[ttpbc_pkg::BYTES_W-1:0];
        return req;
    endfunction

    // mostly adds at valid intervals, with clears, queries and bad intervals mixed in
    function automatic t_endpoint_req random_request();
        t_endpoint_req req;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            req.kind = ttpbc_pkg::KIND_CLEAR;
        else if (pick < 70)
            req.kind = ttpbc_pkg::KIND_ADD;
        else if (pick < 92)
            req.kind = KIND_QUERY;
        else
            req.kind = KIND_SPARE;
        req.is_low_speed = ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 99) < 85)
            req.poll_exponent = ttpbc_pkg::EXPO_W'($urandom_range(ttpbc_pkg::MIN_EXPONENT,
                                                      ttpbc_pkg::INTERVAL_LIMIT - 1));
        else
            req.poll_exponent = ttpbc_pkg::EXPO_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            req.packet_bytes = '0;
        else if (pick == 1)
            req.packet_bytes = '1;
        else
            req.packet_bytes = ttpbc_pkg::BYTES_W'($urandom_range(0, 1023));
        return req;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic write_reg(input logic [ttpbc_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[ttpbc_pkg::CFG_DATA_W-1:0];
        case (idx)
            ttpbc_pkg::CFG_LIMIT:    cfg_limit = data[ttpbc_pkg::LIMIT_W-1:0];
            ttpbc_pkg::CFG_FULL_OVH: cfg_full_ovh = data[ttpbc_pkg::OVH_W-1:0];
            ttpbc_pkg::CFG_LOW_OVH:  cfg_low_ovh = data[ttpbc_pkg::OVH_W-1:0];
            ttpbc_pkg::CFG_BPB:      cfg_bpb = data[ttpbc_pkg::BPB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned limit, input int unsigned full_ovh,
                                  input int unsigned low_ovh, input int unsigned bpb);
        write_reg(ttpbc_pkg::CFG_LIMIT, limit);
        write_reg(ttpbc_pkg::CFG_FULL_OVH, full_ovh);
        write_reg(ttpbc_pkg::CFG_LOW_OVH, low_ovh);
        write_reg(ttpbc_pkg::CFG_BPB, bpb);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every item is in and every result out, then let the block settle
    task automatic settle();
        do
            @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // item driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_reports.push_back(predict_report(drv_item));
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    drv_item = pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    i_kind <= drv_item.kind;
                    i_is_low_speed <= drv_item.is_low_speed;
                    i_poll_exponent <= drv_item.poll_exponent;
                    i_packet_bytes <= drv_item.packet_bytes;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                   : $urandom_range(1, 8);
                        case ($urandom_range(0, 3))
                            0:       gap_left <= 0;
                            3:       gap_left <= $urandom_range(9, 45);
                            default: gap_left <= $urandom_range(1, 8);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern, switching to a random mode when each phase ends
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode <= t_rx_mode'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(20, 120);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        stall_tick <= stall_tick + 8'd1;
        case (stall_mode)
            RX_STREAM:   i_stall <= 1'b0;
            RX_RANDOM:   i_stall <= 1'($urandom_range(0, 1));
            RX_LONG:     i_stall <= (stall_tick[3:0] < 4'd11);
            default:     i_stall <= (stall_tick[1:0] == 2'd0);
        endcase
    end

    // result monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_budget_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch($sformatf(
                    "result with no item outstanding: free %0d over %0b rej %0b",
                    o_blocks_free, o_oversubscribed, o_rejected));
            end else begin
                want = expected_reports.pop_front();
                if (o_blocks_free !== want.blocks_free ||
                    o_oversubscribed !== want.oversubscribed ||
                    o_rejected !== want.rejected)
                    flag_mismatch($sformatf(
                        {"result %0d: free exp %0d got %0d, over exp %0b got %0b, ",
                         "rej exp %0b got %0b"},
                        report_idx, want.blocks_free, o_blocks_free, want.oversubscribed,
                        o_oversubscribed, want.rejected, o_rejected));
                report_idx++;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tt_periodic_bandwidth_check_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int phase, n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at reset settings
        pending_reqs.push_back(mk_req(KIND_QUERY, 1'b0, 0, 0));
        pending_reqs.push_back(mk_req(KIND_SPARE, 1'b1, 31, 1023));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 3, 0));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b1, 3, 1023));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 15, 1023));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b1, 4, 1));
        // full speed after low speed keeps the low speed overhead
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 4, 64));
        // intervals out of range
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 2, 100));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b1, 16, 100));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 31, 1023));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b1, 0, 0));
        // slot zero and the used count both saturate
        for (n = 0; n < 7; n++)
            pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b1, 3, 1023));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_CLEAR, 1'b0, 0, 0));
        // remainders carried between slots
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 5, 7));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b0, 5, 300));
        pending_reqs.push_back(mk_req(ttpbc_pkg::KIND_ADD, 1'b1, 6, 9));
        pending_reqs.push_back(mk_req(KIND_QUERY, 1'b0, 0, 0));
        settle();

        // random items under a series of register settings, extremes first
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: apply_settings(0, 0, 0, 64);
                1: apply_settings(32767, 255, 255, 1);
                2: apply_settings($urandom_range(500, 5000), $urandom_range(0, 255),
                                  $urandom_range(0, 255), 0);
                3: apply_settings($urandom_range(500, 5000), $urandom_range(0, 255),
                                  $urandom_range(0, 255), 127);
                default: apply_settings($urandom_range(0, 32767), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(1, 64));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_reqs.push_back(random_request());
            settle();
        end

        if (mismatch_count == 0)
            $display("tt_periodic_bandwidth_check_tb: PASS");
        else
            $display("tt_periodic_bandwidth_check_tb: FAIL");
        $finish;
    end

endmodule
